// ===== rtl/core/imuf_pkg.sv =====
`timescale 1ns / 1ps

package imuf_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [3:0] FRAME_LEN  = 4'd11;
  localparam logic [3:0] FRAME_LAST = 4'd10;
  localparam logic [3:0] TYPE_POS   = 4'd1;
  localparam logic [3:0] DATA_FIRST = 4'd2;
  localparam logic [3:0] DATA_LAST  = 4'd7;

  localparam int RANGE_W  = 5;
  localparam int TRIM_W   = 11;
  localparam int CFG_W    = 11;
  localparam int ACC_P_W  = 22;
  localparam int ACC_M_W  = 35;
  localparam int ACC_Q_W  = 20;
  localparam int ACC_W    = 19;

  localparam logic [0:0] CFG_ACCEL_RANGE = 1'b0;
  localparam logic [0:0] CFG_PITCH_TRIM  = 1'b1;

  localparam logic [RANGE_W-1:0]       ACCEL_RANGE_RST = 5'd16;
  localparam logic signed [TRIM_W-1:0] PITCH_TRIM_RST  = -11'sd200;

  localparam logic [13:0] ACC_SCALE = 14'd9800;
  localparam logic signed [ACC_M_W-1:0] ACC_ROUND = 35'sd32767;
  localparam logic signed [ACC_Q_W-1:0] ACC_Q_MAX = 20'sd262143;
  localparam logic signed [ACC_Q_W-1:0] ACC_Q_MIN = -20'sd262144;

  localparam logic [14:0] ANG_SCALE = 15'd18000;
  localparam logic [15:0] HALF_TURN = 16'd18000;
  localparam logic [15:0] RAW_HALF  = 16'h8000;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_ACCEL   = 3'd1,
    KIND_GYRO    = 3'd2,
    KIND_ANGLE   = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

  typedef struct packed {
    logic s2_load;
    logic s3_load;
    logic s4_load;
  } pipe_ctl_t;

  function automatic logic [15:0] angle_cd(logic [15:0] raw);
    logic [30:0] p;
    p = 31'(raw) * 31'(ANG_SCALE);
    return p[30:15];
  endfunction

  function automatic logic [15:0] half_turn(logic [15:0] raw);
    logic [15:0] a;
    a = angle_cd(raw);
    return (raw <= RAW_HALF) ? (a + HALF_TURN) : (a - HALF_TURN);
  endfunction

endpackage

// ===== rtl/core/imu_uart_frame_parser_unit.sv =====
`timescale 1ns / 1ps

// Serial frame parser for a nine-axis inertial sensor. Each input transaction carries one
// received byte; the block hunts for the 0x55 header, collects 11-byte frames and keeps the
// accel, gyro and angle words of the last frame of each type, and every byte produces one
// output transaction with the converted readings as they stand after that byte. One byte is
// taken per clock cycle while the input is not stalled by back-pressure from the output; after
// the input register, each byte's result passes through the frame state register, the
// raw-times-range multiply register and the output register. Configuration writes take effect
// on the next cycle.

module imu_uart_frame_parser_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             in_rx_byte,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_frame_done,
  output logic [2:0]                             out_frame_kind,
  output logic signed [imuf_pkg::ACC_W-1:0]      out_accel_x,
  output logic signed [imuf_pkg::ACC_W-1:0]      out_accel_y,
  output logic signed [imuf_pkg::ACC_W-1:0]      out_accel_z,
  output logic signed [15:0]                     out_gyro_x,
  output logic signed [15:0]                     out_gyro_y,
  output logic signed [15:0]                     out_gyro_z,
  output logic [15:0]                            out_roll_shifted,
  output logic signed [16:0]                     out_pitch_shifted,
  output logic [15:0]                            out_yaw_angle,
  input  logic                                   cfg_we,
  input  logic [0:0]                             cfg_index,
  input  logic [imuf_pkg::CFG_W-1:0]             cfg_wdata
);

  logic                                v1_r, v2_r, v3_r, v4_r;
  logic                                v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic                                free1, free2, free3;
  logic                                in_take;
  logic [7:0]                          byte1_r;
  imuf_pkg::pipe_ctl_t                 ctl;
  logic [imuf_pkg::RANGE_W-1:0]        accel_range_r;
  logic signed [imuf_pkg::TRIM_W-1:0]  pitch_trim_r;
  logic                                sync_done;
  imuf_pkg::kind_t                     sync_kind;
  logic [47:0]                         accel_words;
  logic [47:0]                         gyro_words;
  logic [47:0]                         angle_words;

  always_comb begin
    ctl.s4_load = v3_r && (!v4_r || !out_stall);
    free3       = !v3_r || ctl.s4_load;
    ctl.s3_load = v2_r && free3;
    free2       = !v2_r || ctl.s3_load;
    ctl.s2_load = v1_r && free2;
    free1       = !v1_r || ctl.s2_load;
    in_take     = in_valid && free1;
    v1_nxt      = in_take || (v1_r && !ctl.s2_load);
    v2_nxt      = ctl.s2_load || (v2_r && !ctl.s3_load);
    v3_nxt      = ctl.s3_load || (v3_r && !ctl.s4_load);
    v4_nxt      = ctl.s4_load || (v4_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte1_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_range_r <= imuf_pkg::ACCEL_RANGE_RST;
      pitch_trim_r  <= imuf_pkg::PITCH_TRIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imuf_pkg::CFG_ACCEL_RANGE: accel_range_r <= cfg_wdata[imuf_pkg::RANGE_W-1:0];
        imuf_pkg::CFG_PITCH_TRIM:  pitch_trim_r  <= $signed(cfg_wdata[imuf_pkg::TRIM_W-1:0]);
      endcase
    end
  end

  assign in_stall  = !free1;
  assign out_valid = v4_r;

  imuf_frame_sync u_sync (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .rx_byte     (byte1_r),
    .done        (sync_done),
    .kind        (sync_kind),
    .accel_words (accel_words),
    .gyro_words  (gyro_words),
    .angle_words (angle_words)
  );

  imuf_convert u_conv (
    .clk           (clk),
    .ctl           (ctl),
    .done          (sync_done),
    .kind          (sync_kind),
    .accel_words   (accel_words),
    .gyro_words    (gyro_words),
    .angle_words   (angle_words),
    .accel_range   (accel_range_r),
    .pitch_trim    (pitch_trim_r),
    .frame_done    (out_frame_done),
    .frame_kind    (out_frame_kind),
    .accel_x       (out_accel_x),
    .accel_y       (out_accel_y),
    .accel_z       (out_accel_z),
    .gyro_x        (out_gyro_x),
    .gyro_y        (out_gyro_y),
    .gyro_z        (out_gyro_z),
    .roll_shifted  (out_roll_shifted),
    .pitch_shifted (out_pitch_shifted),
    .yaw_angle     (out_yaw_angle)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_done == (out_frame_kind != imuf_pkg::KIND_NONE)))
    else $error("Frame completion flag disagrees with the frame kind.");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_stall))
    else $error("Input stalled while the pipeline still has room.");

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.s2_load |=> v2_r)
    else $error("A byte entered the frame stage but its result was lost.");

endmodule

// ===== rtl/core/imuf_frame_sync.sv =====
`timescale 1ns / 1ps

module imuf_frame_sync (
  input  logic                clk,
  input  logic                rst_n,
  input  imuf_pkg::pipe_ctl_t ctl,
  input  logic [7:0]          rx_byte,
  output logic                done,
  output imuf_pkg::kind_t     kind,
  output logic [47:0]         accel_words,
  output logic [47:0]         gyro_words,
  output logic [47:0]         angle_words
);

  logic [3:0]      bc_r;
  logic [3:0]      bc_nxt;
  logic [3:0]      bc_eff;
  logic [2:0]      data_idx;
  logic [7:0]      type_r;
  logic [7:0]      data_r [6];
  logic            done_r;
  logic            done_nxt;
  imuf_pkg::kind_t kind_r;
  imuf_pkg::kind_t kind_nxt;
  logic [47:0]     accel_r;
  logic [47:0]     gyro_r;
  logic [47:0]     angle_r;
  logic [47:0]     packed_words;
  logic            hdr_ok;
  logic            frame_end;

  always_comb begin
    bc_eff       = (bc_r >= imuf_pkg::FRAME_LEN) ? 4'd0 : bc_r;
    data_idx     = 3'(bc_eff - imuf_pkg::DATA_FIRST);
    hdr_ok       = (bc_eff != 4'd0) || (rx_byte == imuf_pkg::HDR_BYTE);
    frame_end    = hdr_ok && (bc_eff == imuf_pkg::FRAME_LAST);
    packed_words = {data_r[5], data_r[4], data_r[3], data_r[2], data_r[1], data_r[0]};
    done_nxt     = frame_end;
    kind_nxt     = imuf_pkg::KIND_NONE;
    if (!hdr_ok || frame_end) begin
      bc_nxt = 4'd0;
    end else begin
      bc_nxt = bc_eff + 4'd1;
    end
    if (frame_end) begin
      unique case (type_r)
        imuf_pkg::TYPE_ACCEL: kind_nxt = imuf_pkg::KIND_ACCEL;
        imuf_pkg::TYPE_GYRO:  kind_nxt = imuf_pkg::KIND_GYRO;
        imuf_pkg::TYPE_ANGLE: kind_nxt = imuf_pkg::KIND_ANGLE;
        default:              kind_nxt = imuf_pkg::KIND_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r    <= 4'd0;
      done_r  <= 1'b0;
      kind_r  <= imuf_pkg::KIND_NONE;
      accel_r <= '0;
      gyro_r  <= '0;
      angle_r <= '0;
    end else if (ctl.s2_load) begin
      bc_r   <= bc_nxt;
      done_r <= done_nxt;
      kind_r <= kind_nxt;
      if (kind_nxt == imuf_pkg::KIND_ACCEL) begin
        accel_r <= packed_words;
      end
      if (kind_nxt == imuf_pkg::KIND_GYRO) begin
        gyro_r <= packed_words;
      end
      if (kind_nxt == imuf_pkg::KIND_ANGLE) begin
        angle_r <= packed_words;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      if (bc_eff == imuf_pkg::TYPE_POS) begin
        type_r <= rx_byte;
      end
      if ((bc_eff >= imuf_pkg::DATA_FIRST) && (bc_eff <= imuf_pkg::DATA_LAST)) begin
        data_r[data_idx] <= rx_byte;
      end
    end
  end

  assign done        = done_r;
  assign kind        = kind_r;
  assign accel_words = accel_r;
  assign gyro_words  = gyro_r;
  assign angle_words = angle_r;

  assert property (@(posedge clk) disable iff (!rst_n) bc_r < imuf_pkg::FRAME_LEN)
    else $error("Byte count has run past the frame length.");

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> (bc_r == 4'd0))
    else $error("A completed frame has not restarted the byte count.");

endmodule

// ===== rtl/core/imuf_convert.sv =====
`timescale 1ns / 1ps

module imuf_convert (
  input  logic                                   clk,
  input  imuf_pkg::pipe_ctl_t                    ctl,
  input  logic                                   done,
  input  imuf_pkg::kind_t                        kind,
  input  logic [47:0]                            accel_words,
  input  logic [47:0]                            gyro_words,
  input  logic [47:0]                            angle_words,
  input  logic [imuf_pkg::RANGE_W-1:0]           accel_range,
  input  logic signed [imuf_pkg::TRIM_W-1:0]     pitch_trim,
  output logic                                   frame_done,
  output logic [2:0]                             frame_kind,
  output logic signed [imuf_pkg::ACC_W-1:0]      accel_x,
  output logic signed [imuf_pkg::ACC_W-1:0]      accel_y,
  output logic signed [imuf_pkg::ACC_W-1:0]      accel_z,
  output logic signed [15:0]                     gyro_x,
  output logic signed [15:0]                     gyro_y,
  output logic signed [15:0]                     gyro_z,
  output logic [15:0]                            roll_shifted,
  output logic signed [16:0]                     pitch_shifted,
  output logic [15:0]                            yaw_angle
);

  logic                                done3_r;
  imuf_pkg::kind_t                     kind3_r;
  logic signed [imuf_pkg::ACC_P_W-1:0] accp_nxt [3];
  logic signed [imuf_pkg::ACC_P_W-1:0] accp3_r  [3];
  logic [15:0]                         gyro3_r  [3];
  logic [15:0]                         roll_nxt;
  logic [15:0]                         roll3_r;
  logic signed [17:0]                  pitch_sum;
  logic [16:0]                         pitch3_r;
  logic [15:0]                         yaw_nxt;
  logic [15:0]                         yaw3_r;

  logic signed [imuf_pkg::ACC_M_W-1:0] accm     [3];
  logic signed [imuf_pkg::ACC_M_W-1:0] accm_adj [3];
  logic signed [imuf_pkg::ACC_Q_W-1:0] accq     [3];
  logic signed [imuf_pkg::ACC_W-1:0]   acc_nxt  [3];
  logic signed [imuf_pkg::ACC_W-1:0]   acc4_r   [3];
  logic                                done4_r;
  imuf_pkg::kind_t                     kind4_r;
  logic [15:0]                         gyro4_r  [3];
  logic [15:0]                         roll4_r;
  logic [16:0]                         pitch4_r;
  logic [15:0]                         yaw4_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      accp_nxt[k] = imuf_pkg::ACC_P_W'($signed(accel_words[16*k +: 16]) *
                                       $signed({1'b0, accel_range}));
    end
    roll_nxt  = imuf_pkg::half_turn(angle_words[15:0]);
    pitch_sum = $signed({2'b00, imuf_pkg::half_turn(angle_words[31:16])}) + 18'(pitch_trim);
    yaw_nxt   = imuf_pkg::angle_cd(angle_words[47:32]);
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      done3_r  <= done;
      kind3_r  <= kind;
      for (int k = 0; k < 3; k++) begin
        accp3_r[k] <= accp_nxt[k];
        gyro3_r[k] <= gyro_words[16*k +: 16];
      end
      roll3_r  <= roll_nxt;
      pitch3_r <= pitch_sum[16:0];
      yaw3_r   <= yaw_nxt;
    end
  end

  // Division by 32768 truncates towards zero as negative products are biased first.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      accm[k]     = imuf_pkg::ACC_M_W'(accp3_r[k]) * imuf_pkg::ACC_M_W'(imuf_pkg::ACC_SCALE);
      accm_adj[k] = accm[k] + (accm[k][imuf_pkg::ACC_M_W-1] ? imuf_pkg::ACC_ROUND : '0);
      accq[k]     = accm_adj[k][imuf_pkg::ACC_M_W-1:imuf_pkg::ACC_M_W-imuf_pkg::ACC_Q_W];
      priority if (accq[k] > imuf_pkg::ACC_Q_MAX) begin
        acc_nxt[k] = imuf_pkg::ACC_Q_MAX[imuf_pkg::ACC_W-1:0];
      end else if (accq[k] < imuf_pkg::ACC_Q_MIN) begin
        acc_nxt[k] = imuf_pkg::ACC_Q_MIN[imuf_pkg::ACC_W-1:0];
      end else begin
        acc_nxt[k] = accq[k][imuf_pkg::ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s4_load) begin
      done4_r  <= done3_r;
      kind4_r  <= kind3_r;
      for (int k = 0; k < 3; k++) begin
        acc4_r[k]  <= acc_nxt[k];
        gyro4_r[k] <= gyro3_r[k];
      end
      roll4_r  <= roll3_r;
      pitch4_r <= pitch3_r;
      yaw4_r   <= yaw3_r;
    end
  end

  assign frame_done    = done4_r;
  assign frame_kind    = kind4_r;
  assign accel_x       = acc4_r[0];
  assign accel_y       = acc4_r[1];
  assign accel_z       = acc4_r[2];
  assign gyro_x        = gyro4_r[0];
  assign gyro_y        = gyro4_r[1];
  assign gyro_z        = gyro4_r[2];
  assign roll_shifted  = roll4_r;
  assign pitch_shifted = pitch4_r;
  assign yaw_angle     = yaw4_r;

endmodule

// ===== dv/imu_uart_frame_parser_unit_tb.sv =====
`timescale 1ns / 1ps

module imu_uart_frame_parser_unit_tb;
  import imuf_pkg::*;

  typedef struct {
    logic                     done;
    kind_t                    kind;
    logic signed [ACC_W-1:0]  ax;
    logic signed [ACC_W-1:0]  ay;
    logic signed [ACC_W-1:0]  az;
    logic signed [15:0]       gx;
    logic signed [15:0]       gy;
    logic signed [15:0]       gz;
    logic [15:0]              roll;
    logic signed [16:0]       pitch;
    logic [15:0]              yaw;
  } reading_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_rx_byte = 8'h00;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_frame_done;
  logic [2:0]               out_frame_kind;
  logic signed [ACC_W-1:0]  out_accel_x;
  logic signed [ACC_W-1:0]  out_accel_y;
  logic signed [ACC_W-1:0]  out_accel_z;
  logic signed [15:0]       out_gyro_x;
  logic signed [15:0]       out_gyro_y;
  logic signed [15:0]       out_gyro_z;
  logic [15:0]              out_roll_shifted;
  logic signed [16:0]       out_pitch_shifted;
  logic [15:0]              out_yaw_angle;
  logic                     cfg_we = 1'b0;
  logic [0:0]               cfg_index = CFG_ACCEL_RANGE;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  imu_uart_frame_parser_unit DUT (.*);

  // Predictor state.
  logic [RANGE_W-1:0] range_g = ACCEL_RANGE_RST;
  int                 trim_cd = int'(PITCH_TRIM_RST);
  int                 frame_cnt = 0;
  logic [7:0]         frame_buf [0:10];
  logic [47:0]        acc_words = '0;
  logic [47:0]        gyr_words = '0;
  logic [47:0]        ang_words = '0;

  reading_t pending_readings [$];

  int err_count = 0;
  int n_bytes = 0;
  int n_accel = 0;
  int n_gyro = 0;
  int n_angle = 0;
  int n_other = 0;
  int n_writes = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int stall_hold = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [ACC_W-1:0] accel_mm(logic [15:0] raw);
    longint p;
    p = longint'($signed(raw)) * longint'(range_g) * 9800 / 32768;
    if (p > 262143) p = 262143;
    if (p < -262144) p = -262144;
    return p[ACC_W-1:0];
  endfunction

  function automatic int angle_cdeg(logic [15:0] raw);
    logic [31:0] p;
    p = 32'(raw) * 32'd18000;
    return int'(p >> 15);
  endfunction

  function automatic int half_turn_cdeg(logic [15:0] raw);
    return (raw <= 16'h8000) ? angle_cdeg(raw) + 18000 : angle_cdeg(raw) - 18000;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    reading_t    r;
    logic [47:0] words;
    int          ht;
    int          pt;
    r.done = 1'b0;
    r.kind = KIND_NONE;
    if (frame_cnt >= FRAME_LEN) frame_cnt = 0;
    frame_buf[frame_cnt] = b;
    if (frame_buf[0] != HDR_BYTE) begin
      frame_cnt = 0;
    end else begin
      frame_cnt++;
      if (frame_cnt == FRAME_LEN) begin
        frame_cnt = 0;
        r.done = 1'b1;
        words = {frame_buf[7], frame_buf[6], frame_buf[5],
                 frame_buf[4], frame_buf[3], frame_buf[2]};
        case (frame_buf[TYPE_POS])
          TYPE_ACCEL: begin
            acc_words = words;
            r.kind = KIND_ACCEL;
            n_accel++;
          end
          TYPE_GYRO: begin
            gyr_words = words;
            r.kind = KIND_GYRO;
            n_gyro++;
          end
          TYPE_ANGLE: begin
            ang_words = words;
            r.kind = KIND_ANGLE;
            n_angle++;
          end
          default: begin
            r.kind = KIND_UNKNOWN;
            n_other++;
          end
        endcase
      end
    end
    r.ax = accel_mm(acc_words[15:0]);
    r.ay = accel_mm(acc_words[31:16]);
    r.az = accel_mm(acc_words[47:32]);
    r.gx = gyr_words[15:0];
    r.gy = gyr_words[31:16];
    r.gz = gyr_words[47:32];
    ht = half_turn_cdeg(ang_words[15:0]);
    r.roll = ht[15:0];
    pt = half_turn_cdeg(ang_words[31:16]) + trim_cd;
    r.pitch = pt[16:0];
    ht = angle_cdeg(ang_words[47:32]);
    r.yaw = ht[15:0];
    pending_readings.push_back(r);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    reading_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("result transaction with no reading outstanding");
        err_count++;
      end else begin
        r = pending_readings.pop_front();
        check_field("frame_done", r.done, out_frame_done);
        check_field("frame_kind", r.kind, out_frame_kind);
        check_field("accel_x", r.ax, out_accel_x);
        check_field("accel_y", r.ay, out_accel_y);
        check_field("accel_z", r.az, out_accel_z);
        check_field("gyro_x", r.gx, out_gyro_x);
        check_field("gyro_y", r.gy, out_gyro_y);
        check_field("gyro_z", r.gz, out_gyro_z);
        check_field("roll_shifted", r.roll, out_roll_shifted);
        check_field("pitch_shifted", r.pitch, out_pitch_shifted);
        check_field("yaw_angle", r.yaw, out_yaw_angle);
      end
    end
  end

  // The receiver picks a new stall density, including calm stretches, whenever its hold counter runs out.
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_hold = $urandom_range(200, 30);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end else begin
      stall_hold--;
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    parse_byte(b);
    n_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] w0,
                            input logic [15:0] w1, input logic [15:0] w2);
    send_byte(HDR_BYTE);
    send_byte(kind_byte);
    send_byte(w0[7:0]);
    send_byte(w0[15:8]);
    send_byte(w1[7:0]);
    send_byte(w1[15:8]);
    send_byte(w2[7:0]);
    send_byte(w2[15:8]);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(8'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACCEL_RANGE) range_g = val[RANGE_W-1:0];
    else trim_cd = int'($signed(val[TRIM_W-1:0]));
    n_writes++;
  endtask

  function automatic logic [15:0] pick_word();
    if ($urandom_range(7) != 0) return 16'($urandom);
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'h8001;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == HDR_BYTE) b = 8'h00;
    return b;
  endfunction

  task automatic test_header_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_frame(TYPE_GYRO, 16'h8000, 16'h7FFF, 16'hFFFF);
  endtask

  task automatic test_frame_kinds();
    send_frame(TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0001);
    send_frame(TYPE_ANGLE, 16'h8000, 16'h8001, 16'hFFFF);
    send_frame(HDR_BYTE, 16'h5555, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_ACCEL_RANGE, 11'd0);
    send_byte(8'h00);
    write_reg(CFG_ACCEL_RANGE, 11'd31);
    send_byte(8'h00);
    write_reg(CFG_ACCEL_RANGE, 11'd1);
    send_byte(8'h00);
    write_reg(CFG_PITCH_TRIM, 11'h400);
    send_byte(8'h00);
    write_reg(CFG_PITCH_TRIM, 11'h3FF);
    send_byte(8'h00);
    write_reg(CFG_PITCH_TRIM, 11'(-1000));
    send_byte(8'h00);
    write_reg(CFG_PITCH_TRIM, 11'd1000);
    send_byte(8'h00);
  endtask

  task automatic test_random_traffic();
    int counted;
    int sel;
    int n;
    int t;
    logic [7:0] kind_byte;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_ACCEL_RANGE, 11'($urandom_range(16, 1)));
          t = $urandom_range(2000) - 1000;
          write_reg(CFG_PITCH_TRIM, t[10:0]);
        end
        1: begin
          write_reg(CFG_ACCEL_RANGE, 11'd31);
          write_reg(CFG_PITCH_TRIM, 11'h3FF);
        end
        2: begin
          write_reg(CFG_ACCEL_RANGE, 11'd1);
          write_reg(CFG_PITCH_TRIM, 11'h400);
        end
        default: begin
          write_reg(CFG_ACCEL_RANGE, 11'($urandom_range(31)));
          write_reg(CFG_PITCH_TRIM, 11'($urandom));
        end
      endcase
      counted = 0;
      while (counted < 435) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          case ($urandom_range(2))
            0: kind_byte = TYPE_ACCEL;
            1: kind_byte = TYPE_GYRO;
            default: kind_byte = TYPE_ANGLE;
          endcase
          send_frame(kind_byte, pick_word(), pick_word(), pick_word());
          counted += 11;
        end else if (sel < 80) begin
          send_frame(8'($urandom), pick_word(), pick_word(), pick_word());
          counted += 11;
        end else if (sel < 90) begin
          n = $urandom_range(4, 1);
          repeat (n) send_byte(noise_byte());
        end else begin
          n = $urandom_range(9, 1);
          send_byte(HDR_BYTE);
          repeat (n) send_byte(8'($urandom));
          counted += n + 1;
        end
      end
    end
  endtask

  initial begin
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_header_hunt();
    test_frame_kinds();
    test_config_extremes();
    test_random_traffic();
    drain_results();
    $display("Sent %0d bytes forming %0d accel, %0d gyro, %0d angle and %0d unknown frames.",
             n_bytes, n_accel, n_gyro, n_angle, n_other);
    $display("Wrote %0d register values, covering range and trim extremes.", n_writes);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d readings outstanding.", pending_readings.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
